// ===== hw/rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Request types and protocol constants shared by the command engine modules,
// and the CRC7 byte update used by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdspi_pkg;

  // Request codes on the input channel.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RX    = 1'b1;

  // Result kinds on the output channel.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // SD command numbers with a reply other than plain R1.
  localparam logic [5:0] CMD_CHECK_VOLTAGE     = 6'd8;
  localparam logic [5:0] CMD_STOP_TRANSMISSION = 6'd12;
  localparam logic [5:0] CMD_SEND_STATUS       = 6'd13;
  localparam logic [5:0] CMD_READ_OCR          = 6'd58;

  // Frame and bus constants.
  localparam logic [7:0]  START_TOKEN      = 8'h40;
  localparam logic [7:0]  FILL_BYTE        = 8'hFF;
  localparam logic [7:0]  BUSY_BYTE        = 8'h00;
  localparam logic [6:0]  CRC7_POLY        = 7'h09;
  localparam logic [15:0] POLL_LIMIT_RESET = 16'd255;

  // Input request: a command start or a byte received from the card.
  typedef struct packed {
    logic        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } sdspi_in_t;

  // Result: the next byte to send, or the finished response.
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [7:0]  r1;
    logic [31:0] extended;
    logic        timed_out;
  } sdspi_out_t;

  // CRC7 (x^7 + x^3 + 1) advanced over one byte, most significant bit first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                           input logic [7:0] data);
    logic [6:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb  = crc[6] ^ data[k];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdspi_fsm.sv =====
// ----------------------------------------------------------------------------
// SD SPI command sequencer
// Holds the command state and, while step is high, turns one request per cycle into at most one result:
// frame bytes with a running CRC7, response polling, extra reads and busy wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdspi_fsm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire sdspi_pkg::sdspi_in_t  item,
  input  wire logic [15:0]           poll_limit,
  output sdspi_pkg::sdspi_out_t      res,
  output logic                       res_valid
);

  // Phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_FRAME   = 3'd1;
  localparam logic [2:0] PH_PRE     = 3'd2;
  localparam logic [2:0] PH_POLL    = 3'd3;
  localparam logic [2:0] PH_EXTRA   = 3'd4;
  localparam logic [2:0] PH_POST    = 3'd5;
  localparam logic [2:0] PH_BUSY    = 3'd6;
  localparam logic [2:0] PH_BUSYEND = 3'd7;

  // Reply kinds.
  localparam logic [2:0] RK_R1  = 3'd0;
  localparam logic [2:0] RK_R1B = 3'd1;
  localparam logic [2:0] RK_R2  = 3'd2;
  localparam logic [2:0] RK_R3  = 3'd3;
  localparam logic [2:0] RK_R7  = 3'd4;

  localparam logic [2:0] LAST_ARG_BYTE = 3'd3;
  localparam logic [2:0] FRAME_TAIL    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [2:0]  rkind_r, rkind_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [6:0]  crc_r, crc_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [31:0] extra_r, extra_nxt;
  logic        tmo_r, tmo_nxt;

  logic [7:0]  send_byte;
  logic        fin;
  logic [7:0]  token;
  logic [7:0]  arg_byte;
  logic [2:0]  needs;
  logic        tail_fin;
  logic [2:0]  tail_phase;

  function automatic logic [7:0] START_TOKEN_OR(input logic [5:0] idx);
    return sdspi_pkg::START_TOKEN | {2'b00, idx};
  endfunction

  // Start token of a new frame.
  assign token = START_TOKEN_OR(item.cmd_index);

  // Argument byte at the current frame position, most significant first.
  always_comb begin
    unique case (bcnt_r[1:0])
      2'd0:    arg_byte = arg_r[31:24];
      2'd1:    arg_byte = arg_r[23:16];
      2'd2:    arg_byte = arg_r[15:8];
      default: arg_byte = arg_r[7:0];
    endcase
  end

  // Number of extra reply bytes for the current command.
  always_comb begin
    unique case (rkind_r)
      RK_R7, RK_R3: needs = 3'd4;
      RK_R2:        needs = 3'd1;
      default:      needs = 3'd0;
    endcase
  end

  // After the response (or its timeout) R1b goes on to the busy wait.
  assign tail_fin   = (rkind_r != RK_R1B);
  assign tail_phase = tail_fin ? PH_IDLE : PH_BUSY;

  // Next state and the byte or response for this request.
  always_comb begin
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    poll_nxt  = poll_r;
    rkind_nxt = rkind_r;
    arg_nxt   = arg_r;
    crc_nxt   = crc_r;
    first_nxt = first_r;
    extra_nxt = extra_r;
    tmo_nxt   = tmo_r;
    send_byte = sdspi_pkg::FILL_BYTE;
    fin       = 1'b0;
    res_valid = 1'b1;

    if (item.command == sdspi_pkg::CMD_START) begin
      // A start always restarts the sequence, whatever is running.
      arg_nxt   = item.argument;
      crc_nxt   = sdspi_pkg::crc7_byte(7'd0, token);
      first_nxt = sdspi_pkg::FILL_BYTE;
      extra_nxt = '1;
      tmo_nxt   = 1'b0;
      poll_nxt  = '0;
      bcnt_nxt  = '0;
      phase_nxt = PH_FRAME;
      send_byte = token;
      priority if (item.cmd_index == sdspi_pkg::CMD_CHECK_VOLTAGE) begin
        rkind_nxt = RK_R7;
      end else if (item.cmd_index == sdspi_pkg::CMD_READ_OCR) begin
        rkind_nxt = RK_R3;
      end else if (item.cmd_index == sdspi_pkg::CMD_STOP_TRANSMISSION) begin
        rkind_nxt = RK_R1B;
      end else if (item.cmd_index == sdspi_pkg::CMD_SEND_STATUS) begin
        rkind_nxt = RK_R2;
      end else begin
        rkind_nxt = RK_R1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          // A received byte with no command running is dropped.
          res_valid = 1'b0;
        end
        PH_FRAME: begin
          if (bcnt_r < FRAME_TAIL) begin
            bcnt_nxt = bcnt_r + 3'd1;
            if (bcnt_r <= LAST_ARG_BYTE) begin
              send_byte = arg_byte;
              crc_nxt   = sdspi_pkg::crc7_byte(crc_r, arg_byte);
            end else begin
              send_byte = {crc_r, 1'b1};
            end
          end else if (rkind_r == RK_R1B) begin
            phase_nxt = PH_PRE;
          end else if (poll_limit == '0) begin
            tmo_nxt   = 1'b1;
            first_nxt = sdspi_pkg::FILL_BYTE;
            phase_nxt = tail_phase;
            fin       = tail_fin;
          end else begin
            poll_nxt  = 16'd1;
            phase_nxt = PH_POLL;
          end
        end
        PH_PRE: begin
          if (poll_limit == '0) begin
            tmo_nxt   = 1'b1;
            first_nxt = sdspi_pkg::FILL_BYTE;
            phase_nxt = tail_phase;
            fin       = tail_fin;
          end else begin
            poll_nxt  = 16'd1;
            phase_nxt = PH_POLL;
          end
        end
        PH_POLL: begin
          if (item.rx_byte != sdspi_pkg::FILL_BYTE) begin
            first_nxt = item.rx_byte;
            bcnt_nxt  = '0;
            phase_nxt = (needs != 3'd0) ? PH_EXTRA : PH_POST;
          end else if (poll_r >= poll_limit) begin
            tmo_nxt   = 1'b1;
            first_nxt = sdspi_pkg::FILL_BYTE;
            phase_nxt = tail_phase;
            fin       = tail_fin;
          end else begin
            poll_nxt = poll_r + 16'd1;
          end
        end
        PH_EXTRA: begin
          // The first extra byte lands in the top byte.
          unique case (bcnt_r[1:0])
            2'd0:    extra_nxt[31:24] = item.rx_byte;
            2'd1:    extra_nxt[23:16] = item.rx_byte;
            2'd2:    extra_nxt[15:8]  = item.rx_byte;
            default: extra_nxt[7:0]   = item.rx_byte;
          endcase
          bcnt_nxt = bcnt_r + 3'd1;
          if ((bcnt_r + 3'd1) >= needs) begin
            phase_nxt = PH_POST;
          end
        end
        PH_POST: begin
          phase_nxt = tail_phase;
          fin       = tail_fin;
        end
        PH_BUSY: begin
          if (item.rx_byte != sdspi_pkg::BUSY_BYTE) begin
            phase_nxt = PH_BUSYEND;
          end
        end
        default: begin
          // Last dummy byte of the busy wait has been exchanged.
          phase_nxt = PH_IDLE;
          fin       = 1'b1;
        end
      endcase
    end

    if (fin) begin
      res.kind      = sdspi_pkg::KIND_DONE;
      res.tx_byte   = '0;
      res.r1        = first_nxt;
      res.extended  = extra_nxt;
      res.timed_out = tmo_nxt;
    end else begin
      res.kind      = sdspi_pkg::KIND_TX;
      res.tx_byte   = send_byte;
      res.r1        = '0;
      res.extended  = '0;
      res.timed_out = 1'b0;
    end
  end

  // Control state; the frame argument and CRC are loaded by every start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bcnt_r  <= '0;
      poll_r  <= '0;
      rkind_r <= RK_R1;
      first_r <= sdspi_pkg::FILL_BYTE;
      extra_r <= '1;
      tmo_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      poll_r  <= poll_nxt;
      rkind_r <= rkind_nxt;
      first_r <= first_nxt;
      extra_r <= extra_nxt;
      tmo_r   <= tmo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      arg_r <= arg_nxt;
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sd_spi_command_engine.sv =====
// ----------------------------------------------------------------------------
// SD card SPI-mode command engine
// Sequences one SD command exchange in SPI mode, one bus byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries requests: a
//   start with command index and argument, or the byte received from the card
//   for the byte sent last. The output channel (out_valid / out_stall /
//   out_data) returns one result per request: the next byte to shift out, or
//   the finished response (r1, extended bytes, timeout flag). A received byte
//   while no command runs gives no result.
//   The cfg channel writes the response poll limit; it is always ready and
//   should only be written while the engine is idle.
//   A request passes through the input register, then the sequencer logic
//   into the output register. One request is accepted every cycle while the
//   receiver does not stall; the sequencer takes one step per accepted request.
//   Reset (rst_n low, synchronous) empties both registers, returns the
//   sequencer to idle and sets the poll limit to 255.
//   When the receiver stalls with a result held, the input register fills
//   and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_command_engine (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sdspi_pkg::sdspi_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sdspi_pkg::sdspi_out_t      out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [15:0]           cfg_data
);

  logic                  in_vld_r, in_vld_nxt;
  sdspi_pkg::sdspi_in_t  in_item_r;
  logic                  out_vld_r, out_vld_nxt;
  sdspi_pkg::sdspi_out_t out_item_r;
  logic [15:0]           poll_limit_r;

  logic                  adv;
  logic                  in_acc;
  sdspi_pkg::sdspi_out_t res;
  logic                  res_valid;

  // The held request advances when the output register is free or draining.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  sdspi_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (in_item_r),
    .poll_limit (poll_limit_r),
    .res        (res),
    .res_valid  (res_valid)
  );

  // Valid flags of the input and output registers.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (adv && res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      poll_limit_r <= sdspi_pkg::POLL_LIMIT_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        poll_limit_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
    if (adv && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// SD SPI command engine testbench
// Runs SD command exchanges through the engine. A small card model answers
// each byte the engine sends. A directed table opens the run, then random
// commands follow under several poll limits. Every result is compared with
// its table entry where the table gives one, else with an in-bench model of
// the engine's sequencing, and both channels are throttled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_LIMIT  = 10;
  localparam sdspi_pkg::sdspi_out_t NO_RESULT = '0;

  // Sequencer steps and reply formats, as tracked by the bench.
  typedef enum logic [2:0] {
    ENG_IDLE, ENG_FRAME, ENG_PRE, ENG_POLL, ENG_EXTRA, ENG_POST, ENG_BUSY, ENG_BUSYEND
  } eng_phase_e;
  typedef enum logic [2:0] {REPLY_R1, REPLY_R1B, REPLY_R2, REPLY_R3, REPLY_R7} reply_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN, RX_LONG} stall_mode_e;

  // One line of the directed table.
  typedef struct {
    sdspi_pkg::sdspi_in_t  req;
    bit                    typed;
    sdspi_pkg::sdspi_out_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sdspi_pkg::sdspi_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sdspi_pkg::sdspi_out_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [15:0]           cfg_data  = '0;

  // Bench copy of the engine state.
  logic [15:0] poll_limit   = sdspi_pkg::POLL_LIMIT_RESET;
  eng_phase_e  eng_phase    = ENG_IDLE;
  logic [2:0]  frame_pos    = '0;
  logic [15:0] polls_sent   = '0;
  reply_kind_e reply_kind   = REPLY_R1;
  logic [47:0] frame        = '0;
  logic [7:0]  r1_seen      = sdspi_pkg::FILL_BYTE;
  logic [31:0] extra_seen   = '1;
  logic        timeout_seen = 1'b0;

  sdspi_pkg::sdspi_out_t pending_outputs[$];

  int cycle_count      = 0;
  int mismatch_count   = 0;
  int results_due      = 0;
  int commands_started = 0;
  int commands_aborted = 0;
  int idle_bytes       = 0;
  int responses_done   = 0;
  int responses_timed  = 0;
  int burst_left       = 0;

  stall_mode_e stall_mode = RX_FREE;
  int          stall_left = 0;
  int          hold_left  = 0;
  logic [7:0]  stall_mask = 8'b1011_0010;

  sd_spi_command_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Engine model
  // ---------------------------------------------------------------------------

  // CRC7 over the five header bytes of a command frame, bit by bit.
  function automatic logic [6:0] frame_crc7(input logic [39:0] head);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = crc[6] ^ head[i];
      crc = {crc[5:0], 1'b0} ^ (fb ? sdspi_pkg::CRC7_POLY : 7'h00);
    end
    return crc;
  endfunction

  function automatic sdspi_pkg::sdspi_out_t tx_result(input logic [7:0] b);
    sdspi_pkg::sdspi_out_t r;
    r         = '0;
    r.kind    = sdspi_pkg::KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic sdspi_pkg::sdspi_out_t done_result(input logic [7:0]  r1v,
                                                        input logic [31:0] ext,
                                                        input logic        to);
    sdspi_pkg::sdspi_out_t r;
    r           = '0;
    r.kind      = sdspi_pkg::KIND_DONE;
    r.r1        = r1v;
    r.extended  = ext;
    r.timed_out = to;
    return r;
  endfunction

  function automatic int extras_needed();
    if (reply_kind == REPLY_R7 || reply_kind == REPLY_R3) return 4;
    if (reply_kind == REPLY_R2) return 1;
    return 0;
  endfunction

  // After the response (or its timeout): R1b goes on to the busy wait.
  function automatic sdspi_pkg::sdspi_out_t finish_or_busy();
    if (reply_kind == REPLY_R1B) begin
      eng_phase = ENG_BUSY;
      return tx_result(sdspi_pkg::FILL_BYTE);
    end
    eng_phase = ENG_IDLE;
    return done_result(r1_seen, extra_seen, timeout_seen);
  endfunction

  // First poll byte; a zero limit times out without polling.
  function automatic sdspi_pkg::sdspi_out_t begin_polling();
    if (poll_limit == 16'd0) begin
      timeout_seen = 1'b1;
      r1_seen      = sdspi_pkg::FILL_BYTE;
      return finish_or_busy();
    end
    polls_sent = 16'd1;
    eng_phase  = ENG_POLL;
    return tx_result(sdspi_pkg::FILL_BYTE);
  endfunction

  // Advances the bench state by one request; returns 1 when a result is due.
  function automatic bit spi_engine_step(input  sdspi_pkg::sdspi_in_t  req,
                                         output sdspi_pkg::sdspi_out_t res);
    res = '0;
    if (req.command == sdspi_pkg::CMD_START) begin
      frame      = {sdspi_pkg::START_TOKEN | {2'b00, req.cmd_index}, req.argument, 8'h00};
      frame[7:0] = {frame_crc7(frame[47:8]), 1'b1};
      case (req.cmd_index)
        sdspi_pkg::CMD_CHECK_VOLTAGE:     reply_kind = REPLY_R7;
        sdspi_pkg::CMD_READ_OCR:          reply_kind = REPLY_R3;
        sdspi_pkg::CMD_STOP_TRANSMISSION: reply_kind = REPLY_R1B;
        sdspi_pkg::CMD_SEND_STATUS:       reply_kind = REPLY_R2;
        default:                          reply_kind = REPLY_R1;
      endcase
      r1_seen      = sdspi_pkg::FILL_BYTE;
      extra_seen   = '1;
      timeout_seen = 1'b0;
      polls_sent   = '0;
      frame_pos    = '0;
      eng_phase    = ENG_FRAME;
      res          = tx_result(frame[47:40]);
      return 1'b1;
    end
    case (eng_phase)
      ENG_FRAME: begin
        if (frame_pos < 3'd5) begin
          frame_pos++;
          res = tx_result(frame[47 - 8 * int'(frame_pos) -: 8]);
        end else if (reply_kind == REPLY_R1B) begin
          eng_phase = ENG_PRE;
          res       = tx_result(sdspi_pkg::FILL_BYTE);
        end else begin
          res = begin_polling();
        end
      end
      ENG_PRE: res = begin_polling();
      ENG_POLL: begin
        if (req.rx_byte != sdspi_pkg::FILL_BYTE) begin
          r1_seen   = req.rx_byte;
          frame_pos = '0;
          eng_phase = (extras_needed() > 0) ? ENG_EXTRA : ENG_POST;
          res       = tx_result(sdspi_pkg::FILL_BYTE);
        end else if (polls_sent >= poll_limit) begin
          timeout_seen = 1'b1;
          r1_seen      = sdspi_pkg::FILL_BYTE;
          res          = finish_or_busy();
        end else begin
          polls_sent++;
          res = tx_result(sdspi_pkg::FILL_BYTE);
        end
      end
      ENG_EXTRA: begin
        extra_seen[31 - 8 * int'(frame_pos[1:0]) -: 8] = req.rx_byte;
        frame_pos++;
        if (int'(frame_pos) >= extras_needed()) eng_phase = ENG_POST;
        res = tx_result(sdspi_pkg::FILL_BYTE);
      end
      ENG_POST: res = finish_or_busy();
      ENG_BUSY: begin
        if (req.rx_byte != sdspi_pkg::BUSY_BYTE) eng_phase = ENG_BUSYEND;
        res = tx_result(sdspi_pkg::FILL_BYTE);
      end
      ENG_BUSYEND: begin
        eng_phase = ENG_IDLE;
        res       = done_result(r1_seen, extra_seen, timeout_seen);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders and drivers
  // ---------------------------------------------------------------------------

  function automatic sdspi_pkg::sdspi_in_t start_req(input logic [5:0]  idx,
                                                     input logic [31:0] arg);
    sdspi_pkg::sdspi_in_t r;
    r.command   = sdspi_pkg::CMD_START;
    r.cmd_index = idx;
    r.argument  = arg;
    r.rx_byte   = 8'($urandom);
    return r;
  endfunction

  // The unused fields of a received-byte request carry random bits.
  function automatic sdspi_pkg::sdspi_in_t rx_req(input logic [7:0] b);
    sdspi_pkg::sdspi_in_t r;
    r.command   = sdspi_pkg::CMD_RX;
    r.cmd_index = 6'($urandom);
    r.argument  = $urandom;
    r.rx_byte   = b;
    return r;
  endfunction

  // Sends one request in bursts with random gaps, then books its result.
  task automatic send_request(input sdspi_pkg::sdspi_in_t  req, input bit typed,
                              input sdspi_pkg::sdspi_out_t want);
    sdspi_pkg::sdspi_out_t res;
    int                    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    if (spi_engine_step(req, res)) begin
      pending_outputs.push_back(typed ? want : res);
      results_due++;
    end
  endtask

  // Stops sending and waits until every result is back and the pipe is quiet.
  task automatic settle_engine();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_poll_limit(input logic [15:0] value);
    settle_engine();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    poll_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One command with a card that answers sensibly: a number of fill bytes
  // before the reply, a number of busy bytes for R1b.
  task automatic run_command(input bit may_abort);
    logic [5:0] idx;
    logic [7:0] rx;
    int         lim;
    int         pick;
    int         fill_left;
    int         busy_left;
    if ($urandom_range(0, 4) < 2) begin
      case ($urandom_range(0, 3))
        0:       idx = sdspi_pkg::CMD_CHECK_VOLTAGE;
        1:       idx = sdspi_pkg::CMD_STOP_TRANSMISSION;
        2:       idx = sdspi_pkg::CMD_SEND_STATUS;
        default: idx = sdspi_pkg::CMD_READ_OCR;
      endcase
    end else begin
      idx = 6'($urandom);
    end
    lim  = int'(poll_limit);
    pick = $urandom_range(0, 9);
    if (lim == 0) fill_left = 0;
    else if (lim <= 16 && pick < 3) fill_left = lim;       // runs into the timeout
    else if (lim <= 16 && pick < 5) fill_left = lim - 1;   // reply on the last allowed poll
    else fill_left = $urandom_range(0, (lim > 4) ? 3 : lim - 1);
    busy_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    commands_started++;
    send_request(start_req(idx, $urandom), 1'b0, NO_RESULT);
    while (eng_phase != ENG_IDLE) begin
      // Now and then a new start cuts the running command short.
      if (may_abort && $urandom_range(0, 99) < 3) begin
        commands_aborted++;
        return;
      end
      rx = 8'($urandom);
      if (eng_phase == ENG_POLL) begin
        if (fill_left > 0) begin
          rx = sdspi_pkg::FILL_BYTE;
          fill_left--;
        end else begin
          rx = 8'($urandom_range(0, 254));
        end
      end else if (eng_phase == ENG_BUSY) begin
        if (busy_left > 0) begin
          rx = sdspi_pkg::BUSY_BYTE;
          busy_left--;
        end else begin
          rx = 8'($urandom_range(1, 255));
        end
      end
      send_request(rx_req(rx), 1'b0, NO_RESULT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver throttling: free, random, a rotating mask, or long holds.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 160);
    end
    stall_left--;
    case (stall_mode)
      RX_FREE:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      RX_PATTERN: begin
        stall_mask = {stall_mask[6:0], stall_mask[7]};
        out_stall <= stall_mask[0];
      end
      default: begin
        if (hold_left == 0) hold_left = $urandom_range(2, 24);
        hold_left--;
        out_stall <= (hold_left > 11);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sdspi_pkg::sdspi_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected result at cycle %0d: kind %0b tx %h r1 %h ext %h to %0b",
                   cycle_count, out_data.kind, out_data.tx_byte, out_data.r1,
                   out_data.extended, out_data.timed_out);
      end else begin
        want = pending_outputs.pop_front();
        if (want.kind == sdspi_pkg::KIND_DONE) begin
          responses_done++;
          if (want.timed_out) responses_timed++;
        end
        if (out_data.kind !== want.kind || out_data.tx_byte !== want.tx_byte ||
            out_data.r1 !== want.r1 || out_data.extended !== want.extended ||
            out_data.timed_out !== want.timed_out) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"Mismatch at cycle %0d: expected kind %0b tx %h r1 %h ext %h to %0b,",
                      " got kind %0b tx %h r1 %h ext %h to %0b"},
                     cycle_count, want.kind, want.tx_byte, want.r1, want.extended,
                     want.timed_out, out_data.kind, out_data.tx_byte, out_data.r1,
                     out_data.extended, out_data.timed_out);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_outputs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    directed_rows[$];
    logic [15:0] limit_plan[6];
    int          phase_start;
    bit          paused_once;
    paused_once = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset poll limit: a received byte while idle,
    // CMD0 with its well known CRC, the largest index and argument cut short
    // by a new start, then CMD8 with its four extra bytes.
    directed_rows.push_back('{rx_req(sdspi_pkg::FILL_BYTE), 1'b0, NO_RESULT});
    directed_rows.push_back('{start_req(6'd0, 32'h0000_0000), 1'b1, tx_result(8'h40)});
    directed_rows.push_back('{rx_req(8'h00), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'h00), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'h00), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'h00), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'h00), 1'b1, tx_result(8'h95)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(sdspi_pkg::FILL_BYTE)});
    directed_rows.push_back('{rx_req(8'h01), 1'b1, tx_result(sdspi_pkg::FILL_BYTE)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, done_result(8'h01, 32'hFFFF_FFFF, 1'b0)});
    directed_rows.push_back('{start_req(6'd63, 32'hFFFF_FFFF), 1'b1, tx_result(8'h7F)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'hFF)});
    directed_rows.push_back('{start_req(sdspi_pkg::CMD_CHECK_VOLTAGE, 32'h0000_01AA), 1'b1,
                              tx_result(8'h48)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'h00)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'h01)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'hAA)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(8'h87)});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, tx_result(sdspi_pkg::FILL_BYTE)});
    directed_rows.push_back('{rx_req(8'h01), 1'b1, tx_result(sdspi_pkg::FILL_BYTE)});
    directed_rows.push_back('{rx_req(8'h00), 1'b0, NO_RESULT});
    directed_rows.push_back('{rx_req(8'h00), 1'b0, NO_RESULT});
    directed_rows.push_back('{rx_req(8'h01), 1'b0, NO_RESULT});
    directed_rows.push_back('{rx_req(8'hAA), 1'b0, NO_RESULT});
    directed_rows.push_back('{rx_req(8'hFF), 1'b1, done_result(8'h01, 32'h0000_01AA, 1'b0)});
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Random commands under several poll limits, the extremes among them.
    limit_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(2, 10)),
                   16'($urandom_range(1, 65535))};
    foreach (limit_plan[p]) begin
      write_poll_limit(limit_plan[p]);
      phase_start = results_due;
      while (results_due - phase_start < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          idle_bytes++;
          send_request(rx_req(8'($urandom)), 1'b0, NO_RESULT);
        end
        run_command(1'b1);
        // Once, hold off the sender until every result has come back.
        if (!paused_once && p == 3 && results_due - phase_start > 35) begin
          settle_engine();
          paused_once = 1'b1;
        end
      end
      run_command(1'b0);
    end

    settle_engine();
    $display("Covered %0d requests with results over %0d commands, %0d cut short by a new start.",
             results_due, commands_started, commands_aborted);
    $display("Saw %0d finished responses (%0d timed out) and %0d spare received bytes.",
             responses_done, responses_timed, idle_bytes);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
